// ===== sv/lse_pkg.sv =====
// ----------------------------------------------------------------------------
// lse_pkg
// Shared widths, opcodes, status codes and types for the LIFO stack engine.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [OP_W-1:0]   op_t;
    typedef logic [STAT_W-1:0] stat_t;

    localparam op_t OP_CLEAR    = 3'd0;
    localparam op_t OP_PUSH     = 3'd1;
    localparam op_t OP_POP      = 3'd2;
    localparam op_t OP_PEEK     = 3'd3;
    localparam op_t OP_TRAVERSE = 3'd4;

    localparam stat_t STAT_OK    = 2'd0;
    localparam stat_t STAT_FULL  = 2'd1;
    localparam stat_t STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ===== sv/lse_mem.sv =====
// ----------------------------------------------------------------------------
// lse_mem
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lse_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  lse_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     wr_addr,
    input  lse_pkg::word_t    wr_data,
    input  logic [AW-1:0]     rd_addr,
    output lse_pkg::word_t    rd_data
);
    import lse_pkg::*;

    word_t store_mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lse_ctrl.sv =====
// ----------------------------------------------------------------------------
// lse_ctrl
// Request sequencer: entry count, store accesses, traversal walk and the
// result register.
// ----------------------------------------------------------------------------
module lse_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lse_pkg::word_t    s_tdata,
    input  lse_pkg::op_t      s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lse_pkg::word_t    m_tdata,
    output lse_pkg::stat_t    m_tuser,
    output logic              m_tlast,
    output lse_pkg::mem_ctl_t mem_ctl,
    output logic [AW-1:0]     wr_addr,
    output lse_pkg::word_t    wr_data,
    output logic [AW-1:0]     rd_addr,
    input  lse_pkg::word_t    rd_data,
    output logic [CW-1:0]     count
);
    import lse_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_RDWAIT = 1'b1;

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic          state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          trav_reg, trav_next;
    logic          mv_reg, mv_next;
    word_t         md_reg, md_next;
    stat_t         mu_reg, mu_next;
    logic          ml_reg, ml_next;

    logic          out_free;
    logic          accept;
    logic          is_empty;
    logic          is_full;
    logic [CW-1:0] count_dec;
    logic          walk_last;

    assign out_free  = !mv_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_COUNT);
    assign count_dec = count_reg - CW'(1);
    assign walk_last = !trav_reg || ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign wr_data   = s_tdata;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        trav_next  = trav_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        mu_next    = mu_reg;
        ml_next    = ml_reg;
        mem_ctl    = '0;
        wr_addr    = count_reg[AW-1:0];
        rd_addr    = count_dec[AW-1:0];

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        OP_CLEAR: begin
                            count_next = '0;
                            mv_next = 1'b1;
                            md_next = '0;
                            mu_next = STAT_OK;
                            ml_next = 1'b1;
                        end
                        OP_PUSH: begin
                            mv_next = 1'b1;
                            md_next = '0;
                            ml_next = 1'b1;
                            if (is_full) begin
                                mu_next = STAT_FULL;
                            end else begin
                                mu_next = STAT_OK;
                                mem_ctl.wr_en = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP, OP_PEEK, OP_TRAVERSE: begin
                            if (is_empty) begin
                                mv_next = 1'b1;
                                md_next = '0;
                                mu_next = STAT_EMPTY;
                                ml_next = 1'b1;
                            end else begin
                                mem_ctl.rd_en = 1'b1;
                                state_next = S_RDWAIT;
                                trav_next = (s_tuser == OP_TRAVERSE);
                                idx_next = '0;
                                if (s_tuser == OP_TRAVERSE) begin
                                    rd_addr = '0;
                                end
                                if (s_tuser == OP_POP) begin
                                    count_next = count_dec;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = rd_data;
                    mu_next = STAT_OK;
                    ml_next = walk_last;
                    if (walk_last) begin
                        state_next = S_IDLE;
                    end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr = idx_reg + AW'(1);
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            trav_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            trav_reg  <= trav_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        md_reg  <= md_next;
        mu_reg  <= mu_next;
        ml_reg  <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;
    assign count    = count_reg;

endmodule

// ===== sv/lifo_stack_engine.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_engine
// Bounded LIFO stack of signed 32-bit words with clear, push, pop, peek and
// bottom-to-top traverse requests.
// ----------------------------------------------------------------------------
//  channel | ports          | tdata             | tuser        | tlast
//  --------+----------------+-------------------+--------------+------------
//  in      | s_tvalid/ready | push_value [31:0] | opcode [2:0] | -
//  out     | m_tvalid/ready | word_out [31:0]   | status [1:0] | last_of_run
//
//  Clear, push and every error: result registered at the accepting edge.
//  Pop and peek: the synchronous store read, then the result register.
//  Traverse: a store read, then one word per cycle while the result side
//  accepts, paced by the single store read port.
//  Reset zeroes the entry count and output valid and returns to idle; the
//  store is not cleared. A stalled result holds in the output register;
//  read data holds in the store's read register.
// ----------------------------------------------------------------------------
module lifo_stack_engine #(
    parameter int STACK_DEPTH = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  lse_pkg::word_t s_tdata,   // [31:0] push_value
    input  lse_pkg::op_t   s_tuser,   // [2:0] opcode
    output logic           m_tvalid,
    input  logic           m_tready,
    output lse_pkg::word_t m_tdata,   // [31:0] word_out
    output lse_pkg::stat_t m_tuser,   // [1:0] status
    output logic           m_tlast
);
    import lse_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] wr_addr;
    word_t         wr_data;
    logic [AW-1:0] rd_addr;
    word_t         rd_data;
    logic [CW-1:0] count;

    lse_ctrl #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .mem_ctl  (mem_ctl),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .count    (count)
    );

    lse_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(STACK_DEPTH))
        else $error("entry count beyond depth");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STAT_OK)) |-> ((m_tdata == '0) && m_tlast))
        else $error("error result with data or without last");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_PUSH) && (count != CW'(STACK_DEPTH)))
        |=> (count == $past(count) + CW'(1)))
        else $error("accepted push did not grow the stack");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("store read and write in one cycle");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lifo_stack_engine. A shadow copy of the stack
// predicts every response. A short directed table covers the empty and
// extreme-value corners and the unused opcodes; a fill to capacity covers the
// full one. Random fill, drain and balanced bursts follow. Both stream sides
// idle at random; one phase holds off the result side to back up the input.
// ----------------------------------------------------------------------------
module tb;
    import lse_pkg::*;

    localparam int  CLK_PERIOD  = 20;
    localparam int  STACK_DEPTH = 64;
    localparam int  ITEM_TARGET = 500;
    localparam int  HOLD_CYCLES = 300;
    localparam int  TAIL_CYCLES = 8;
    localparam int  CYCLE_LIMIT = 5_000_000;

    // opcodes the block ignores
    localparam op_t OP_RSVD_A = 3'd5;
    localparam op_t OP_RSVD_B = 3'd6;
    localparam op_t OP_RSVD_C = 3'd7;

    typedef struct packed {
        word_t word;
        stat_t status;
        logic  last;
    } resp_t;

    typedef struct packed {
        op_t   op;
        word_t val;
        logic  typed;
        word_t want_word;
        stat_t want_stat;
    } dir_row_t;

    typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;

    localparam int DIR_N = 25;
    localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
        '{OP_POP,      32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY},
        '{OP_PEEK,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_EMPTY},
        '{OP_TRAVERSE, 32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY},
        '{OP_PUSH,     32'h8000_0000, 1'b1, 32'h0000_0000, STAT_OK},
        '{OP_PUSH,     32'h7FFF_FFFF, 1'b1, 32'h0000_0000, STAT_OK},
        '{OP_PUSH,     32'h0000_0000, 1'b1, 32'h0000_0000, STAT_OK},
        '{OP_PUSH,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_OK},
        '{OP_PEEK,     32'h0000_0000, 1'b1, 32'hFFFF_FFFF, STAT_OK},
        '{OP_TRAVERSE, 32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK},
        '{OP_RSVD_A,   32'h1234_5678, 1'b0, 32'h0000_0000, STAT_OK},
        '{OP_POP,      32'h0000_0000, 1'b1, 32'hFFFF_FFFF, STAT_OK},
        '{OP_RSVD_B,   32'hA5A5_A5A5, 1'b0, 32'h0000_0000, STAT_OK},
        '{OP_POP,      32'h0000_0000, 1'b1, 32'h0000_0000, STAT_OK},
        '{OP_RSVD_C,   32'h5A5A_5A5A, 1'b0, 32'h0000_0000, STAT_OK},
        '{OP_PEEK,     32'h0000_0000, 1'b1, 32'h7FFF_FFFF, STAT_OK},
        '{OP_TRAVERSE, 32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK},
        '{OP_POP,      32'h0000_0000, 1'b1, 32'h7FFF_FFFF, STAT_OK},
        '{OP_POP,      32'h0000_0000, 1'b1, 32'h8000_0000, STAT_OK},
        '{OP_POP,      32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY},
        '{OP_PUSH,     32'h0000_0001, 1'b1, 32'h0000_0000, STAT_OK},
        '{OP_CLEAR,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_OK},
        '{OP_PEEK,     32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY},
        '{OP_CLEAR,    32'h0000_0000, 1'b1, 32'h0000_0000, STAT_OK},
        '{OP_PUSH,     32'h2468_ACE0, 1'b1, 32'h0000_0000, STAT_OK},
        '{OP_TRAVERSE, 32'h0000_0000, 1'b0, 32'h0000_0000, STAT_OK}
    };

    logic  aclk = 1'b0;
    logic  aresetn;
    logic  s_tvalid = 1'b0;
    logic  s_tready;
    word_t s_tdata = '0;
    op_t   s_tuser = OP_CLEAR;
    logic  m_tvalid;
    logic  m_tready = 1'b0;
    word_t m_tdata;
    stat_t m_tuser;
    logic  m_tlast;

    // shadow stack and pending responses
    word_t shadow_words [STACK_DEPTH];
    int    shadow_fill = 0;
    resp_t expected_resp [$];

    int    err_count   = 0;
    int    ops_sent    = 0;
    int    cycle_count = 0;
    bit    no_idle     = 1'b0;
    bit    rx_hold_req = 1'b0;
    int    hold_left   = 0;
    int    stall_left  = 0;

    lifo_stack_engine #(.STACK_DEPTH(STACK_DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD/2) aclk = ~aclk;

    initial begin
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lifo_stack_engine regression: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic word_t rand_word();
        if ($urandom_range(0, 7) != 0) return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic op_t pick_op(input op_mix_t mix);
        int r;
        int push_w;
        int pop_w;
        int peek_w;
        int trav_w;
        int clr_w;
        case (mix)
            MIX_GROW: begin
                push_w = 65; pop_w = 10; peek_w = 8; trav_w = 8; clr_w = 3;
            end
            MIX_SHRINK: begin
                push_w = 20; pop_w = 45; peek_w = 13; trav_w = 10; clr_w = 3;
            end
            default: begin
                push_w = 40; pop_w = 30; peek_w = 12; trav_w = 10; clr_w = 3;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < push_w) return OP_PUSH;
        r -= push_w;
        if (r < pop_w) return OP_POP;
        r -= pop_w;
        if (r < peek_w) return OP_PEEK;
        r -= peek_w;
        if (r < trav_w) return OP_TRAVERSE;
        r -= trav_w;
        if (r < clr_w) return OP_CLEAR;
        case ($urandom_range(0, 2))
            0: return OP_RSVD_A;
            1: return OP_RSVD_B;
            default: return OP_RSVD_C;
        endcase
    endfunction

    function automatic void post_result(input word_t w, input stat_t s, input logic l);
        resp_t r;
        r.word   = w;
        r.status = s;
        r.last   = l;
        expected_resp.push_back(r);
    endfunction

    // advance the shadow stack; queue the responses when asked
    function automatic void predict_stack_op(input op_t op, input word_t val, input bit enq);
        int i;
        case (op)
            OP_CLEAR: begin
                shadow_fill = 0;
                if (enq) post_result('0, STAT_OK, 1'b1);
            end
            OP_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    if (enq) post_result('0, STAT_FULL, 1'b1);
                end else begin
                    shadow_words[shadow_fill] = val;
                    shadow_fill++;
                    if (enq) post_result('0, STAT_OK, 1'b1);
                end
            end
            OP_POP: begin
                if (shadow_fill == 0) begin
                    if (enq) post_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    shadow_fill--;
                    if (enq) post_result(shadow_words[shadow_fill], STAT_OK, 1'b1);
                end
            end
            OP_PEEK: begin
                if (shadow_fill == 0) begin
                    if (enq) post_result('0, STAT_EMPTY, 1'b1);
                end else if (enq) begin
                    post_result(shadow_words[shadow_fill-1], STAT_OK, 1'b1);
                end
            end
            OP_TRAVERSE: begin
                if (shadow_fill == 0) begin
                    if (enq) post_result('0, STAT_EMPTY, 1'b1);
                end else if (enq) begin
                    for (i = 0; i < shadow_fill; i++)
                        post_result(shadow_words[i], STAT_OK, i == shadow_fill - 1);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 40)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // result side: random backpressure plus the long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : result_check
        resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_resp.size() == 0) begin
                report_mismatch("unexpected result word_out", m_tdata, '0);
            end else begin
                want = expected_resp.pop_front();
                if (m_tdata !== want.word)
                    report_mismatch("word_out", m_tdata, want.word);
                if (m_tuser !== want.status)
                    report_mismatch("status", {30'd0, m_tuser}, {30'd0, want.status});
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", {31'd0, m_tlast}, {31'd0, want.last});
            end
        end
    end

    task automatic send_request(input op_t op, input word_t val, input logic typed,
                                input word_t want_word, input stat_t want_stat);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        if (op <= OP_TRAVERSE) ops_sent++;
        predict_stack_op(op, val, !typed);
        if (typed) post_result(want_word, want_stat, 1'b1);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_resp.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int      k;
        int      burst;
        op_mix_t mix;

        do @(posedge aclk); while (!aresetn);

        for (k = 0; k < DIR_N; k++)
            send_request(DIR_ROWS[k].op, DIR_ROWS[k].val, DIR_ROWS[k].typed,
                         DIR_ROWS[k].want_word, DIR_ROWS[k].want_stat);

        // fill to capacity, overflow, walk the full stack, then peek and pop
        while (shadow_fill < STACK_DEPTH)
            send_request(OP_PUSH, rand_word(), 1'b0, '0, STAT_OK);
        repeat (3) send_request(OP_PUSH, rand_word(), 1'b1, '0, STAT_FULL);
        send_request(OP_TRAVERSE, '0, 1'b0, '0, STAT_OK);
        send_request(OP_PEEK, '0, 1'b0, '0, STAT_OK);
        send_request(OP_POP, '0, 1'b0, '0, STAT_OK);

        // back up the input behind a stalled result side
        wait_all_results();
        no_idle     = 1'b1;
        rx_hold_req = 1'b1;
        send_request(OP_CLEAR, rand_word(), 1'b0, '0, STAT_OK);
        repeat (40)
            send_request(($urandom_range(0, 4) == 0) ? OP_TRAVERSE : OP_PUSH,
                         rand_word(), 1'b0, '0, STAT_OK);
        wait_all_results();
        no_idle = 1'b0;

        while (ops_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 2))
                0: mix = MIX_GROW;
                1: mix = MIX_SHRINK;
                default: mix = MIX_EVEN;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            burst   = $urandom_range(10, 40);
            repeat (burst) send_request(pick_op(mix), rand_word(), 1'b0, '0, STAT_OK);
        end
        no_idle = 1'b0;

        wait_all_results();
        if (err_count == 0) begin
            $display("lifo_stack_engine regression: pass");
        end else begin
            $display("lifo_stack_engine regression: fail");
        end
        $finish;
    end

endmodule
